### rtl/deq_pkg.sv
// Shared types and constants of the double-ended queue unit.
`default_nettype none

package deq_pkg;

    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Per-operation decision from the pointer logic
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wr_en;
        logic                rd_en;
    } deq_op_t;

endpackage

`default_nettype wire

### rtl/deq_if.sv
// Request and response channel interfaces of the double-ended queue unit.
`default_nettype none

interface deq_req_if;
    import deq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [WORD_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if #(
    parameter int CNT_W = 7
);
    import deq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [WORD_W-1:0]  popped_value;
    logic [CNT_W-1:0]          occupancy;

    modport source (output valid, output status, output popped_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input popped_value, input occupancy,
                    output ready);
endinterface

`default_nettype wire

### rtl/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//  Channel | Dir | Payload                               | Handshake
//  --------+-----+---------------------------------------+--------------
//  req     | in  | kind, value                           | valid / ready
//  rsp     | out | status, popped_value, occupancy       | valid / ready
//
// One word per cycle sustained while rsp.ready holds; each response appears
// in the cycle after its request, set by the store's registered read port.
// Head index and count update at acceptance, so the next word may follow at
// once; a push and a later pop of the same entry fall in different cycles.
// Reset clears rsp.valid, head and count only; the store needs no clearing.
// A stalled response holds the store's read register; req.ready drops only
// while a response waits and rsp.ready is low.
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic              accept;
    deq_op_t           op;
    logic [AW-1:0]     addr;
    logic [CW-1:0]     count_after;
    logic [WORD_W-1:0] rd_data;

    // response stage
    logic                valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [CW-1:0]       occ_reg;
    logic                pop_ok_reg;

    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    deq_ptr #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ptr (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (req.kind),
        .op          (op),
        .addr        (addr),
        .count_after (count_after)
    );

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (op.wr_en),
        .wr_addr (addr),
        .wr_data (req.value),
        .rd_en   (op.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    // payload of the response word; no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= op.status;
            occ_reg    <= count_after;
            pop_ok_reg <= op.rd_en;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.occupancy    = occ_reg;
    assign rsp.popped_value = pop_ok_reg ? $signed(rd_data) : '0;

    // Checks

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("accepted request gave no response word");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_UNDERFLOW) |-> (rsp.occupancy == '0))
        else $error("underflow reported with words stored");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_OVERFLOW) |-> (rsp.occupancy == CW'(DEPTH)))
        else $error("overflow reported below full");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.popped_value == '0))
        else $error("refused operation returned a word");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.occupancy <= CW'(DEPTH)))
        else $error("occupancy beyond depth");

endmodule

`default_nettype wire

### rtl/deq_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/deq_ptr.sv
// Head index and element count of the queue, with store address generation.
`default_nettype none

module deq_ptr #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [deq_pkg::KIND_W-1:0]  kind,
    output deq_pkg::deq_op_t                 op,
    output logic [AW-1:0]                    addr,
    output logic [CW-1:0]                    count_after
);
    import deq_pkg::*;

    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;

    logic          full, empty;
    logic [AW-1:0] head_dec, head_inc;
    logic [SW-1:0] sum_end, sum_last;
    logic [AW-1:0] end_idx, last_idx;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    assign head_dec = (head_reg == '0)       ? LAST_IDX : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0       : head_reg + AW'(1);

    // one past the rear, and the rear itself; both below twice the depth when not empty
    assign sum_end  = SW'(head_reg) + SW'(count_reg);
    assign sum_last = sum_end - SW'(1);
    assign end_idx  = (sum_end  >= DEPTH_SUM) ? AW'(sum_end  - DEPTH_SUM) : AW'(sum_end);
    assign last_idx = (sum_last >= DEPTH_SUM) ? AW'(sum_last - DEPTH_SUM) : AW'(sum_last);

    always_comb
    begin
        op.status  = ST_OK;
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        addr       = head_reg;
        head_next  = head_reg;
        count_next = count_reg;
        case (kind)
            KIND_PUSH_FRONT:
            begin
                addr = head_dec;
                if (full)
                begin
                    op.status = ST_OVERFLOW;
                end
                else
                begin
                    op.wr_en   = accept;
                    head_next  = head_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_PUSH_REAR:
            begin
                addr = end_idx;
                if (full)
                begin
                    op.status = ST_OVERFLOW;
                end
                else
                begin
                    op.wr_en   = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_POP_FRONT:
            begin
                addr = head_reg;
                if (empty)
                begin
                    op.status = ST_UNDERFLOW;
                end
                else
                begin
                    op.rd_en   = accept;
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_POP_REAR:
            begin
                addr = last_idx;
                if (empty)
                begin
                    op.status = ST_UNDERFLOW;
                end
                else
                begin
                    op.rd_en   = accept;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                addr = head_reg;
            end
        endcase
    end

    assign count_after = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
